FILE: sv/rotpt_pkg.sv
// ----------------------------------------------------------------------------
// rotpt_pkg
// shared types, widths and constants of the point rotation core
// ----------------------------------------------------------------------------
package rotpt_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int TRIG_FRAC_BITS = 15;
   localparam int TURN_WIDTH     = 16;

   // pipeline layout
   localparam int NUM_STAGES = 17;
   localparam int STG_TRIG   = 12;
   localparam int STG_PROD   = 13;
   localparam int STG_SUM    = 14;
   localparam int STG_ROUND  = 15;
   localparam int STG_OUT    = 16;

   // angle reduction
   localparam int TURN_UNITS    = 10000;
   localparam int QUARTER_UNITS = 2500;
   localparam int EIGHTH_UNITS  = 1250;
   localparam int TURN_OFFSET   = 4 * TURN_UNITS;
   localparam int TURN_WRAPS    = 7;
   localparam int UNWRAP_WIDTH  = 17;
   localparam int ANGLE_WIDTH   = 14;
   localparam int REST_WIDTH    = 12;
   localparam int KERN_WIDTH    = 11;

   // polynomial arithmetic in q30
   localparam int Q_BITS = 30;

   // kernel angle to radians: 2pi * 2^30 / 10000 split into whole and remainder
   localparam int X_STEP_INT    = 674651;
   localparam int X_STEP_FRAC   = 8852;
   localparam int X_ROUND       = TURN_UNITS / 2;
   localparam int XFRAC_WIDTH   = 24;
   localparam int X_DIV_SHIFT   = 40;
   localparam int XRECIP_WIDTH  = 27;
   localparam logic [XRECIP_WIDTH-1:0] X_DIV_RECIP = XRECIP_WIDTH'(
      ((64'd1 << X_DIV_SHIFT) + 64'(TURN_UNITS - 1)) / 64'(TURN_UNITS));

   // reciprocals for the horner divisors
   localparam int RECIP_WIDTH = 31;

   localparam int DIV_S1 = 42;
   localparam int DIV_S2 = 20;
   localparam int DIV_S3 = 6;
   localparam int DIV_C1 = 56;
   localparam int DIV_C2 = 30;
   localparam int DIV_C3 = 12;

   localparam int DIV_S1_SHIFT = Q_BITS + $clog2(DIV_S1);
   localparam int DIV_S2_SHIFT = Q_BITS + $clog2(DIV_S2);
   localparam int DIV_S3_SHIFT = Q_BITS + $clog2(DIV_S3);
   localparam int DIV_C1_SHIFT = Q_BITS + $clog2(DIV_C1);
   localparam int DIV_C2_SHIFT = Q_BITS + $clog2(DIV_C2);
   localparam int DIV_C3_SHIFT = Q_BITS + $clog2(DIV_C3);

   localparam logic [RECIP_WIDTH-1:0] DIV_S1_RECIP = RECIP_WIDTH'(
      ((64'd1 << DIV_S1_SHIFT) + 64'(DIV_S1 - 1)) / 64'(DIV_S1));
   localparam logic [RECIP_WIDTH-1:0] DIV_S2_RECIP = RECIP_WIDTH'(
      ((64'd1 << DIV_S2_SHIFT) + 64'(DIV_S2 - 1)) / 64'(DIV_S2));
   localparam logic [RECIP_WIDTH-1:0] DIV_S3_RECIP = RECIP_WIDTH'(
      ((64'd1 << DIV_S3_SHIFT) + 64'(DIV_S3 - 1)) / 64'(DIV_S3));
   localparam logic [RECIP_WIDTH-1:0] DIV_C1_RECIP = RECIP_WIDTH'(
      ((64'd1 << DIV_C1_SHIFT) + 64'(DIV_C1 - 1)) / 64'(DIV_C1));
   localparam logic [RECIP_WIDTH-1:0] DIV_C2_RECIP = RECIP_WIDTH'(
      ((64'd1 << DIV_C2_SHIFT) + 64'(DIV_C2 - 1)) / 64'(DIV_C2));
   localparam logic [RECIP_WIDTH-1:0] DIV_C3_RECIP = RECIP_WIDTH'(
      ((64'd1 << DIV_C3_SHIFT) + 64'(DIV_C3 - 1)) / 64'(DIV_C3));

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] origin_x;
      logic signed [COORD_WIDTH-1:0] origin_y;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [TURN_WIDTH-1:0]  turn_hundredths;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rotated_x;
      logic signed [COORD_WIDTH-1:0] rotated_y;
      logic                          saturated;
   } rsp_word_type;

endpackage

FILE: sv/rotpt_ctrl.sv
// ----------------------------------------------------------------------------
// rotpt_ctrl
// valid bits of the pipeline and per-stage load enables, bubbles collapse
// ----------------------------------------------------------------------------
module rotpt_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rotpt_pkg::NUM_STAGES-1:0]    stage_en
);

   localparam int LAST = rotpt_pkg::NUM_STAGES - 1;

   logic [LAST:0] valid_ff;
   logic [LAST:0] valid_in;

   assign stage_en[LAST] = !valid_ff[LAST] || !rsp_stall;

   for (genvar g = 0; g < LAST; g++) begin : g_en
      assign stage_en[g] = !valid_ff[g] || stage_en[g+1];
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i <= LAST; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[LAST];

endmodule

FILE: sv/rotpt_trig.sv
// ----------------------------------------------------------------------------
// rotpt_trig
// turn reduction and pipelined horner sine / cosine in q30, quadrant mapping
// ----------------------------------------------------------------------------
module rotpt_trig #(
   parameter int TRIG_FRAC_BITS = rotpt_pkg::TRIG_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic [rotpt_pkg::STG_TRIG:0]          stage_en,
   input  logic signed [rotpt_pkg::TURN_WIDTH-1:0] turn,
   output logic signed [TRIG_FRAC_BITS+1:0]      cos_val,
   output logic signed [TRIG_FRAC_BITS+1:0]      sin_val
);

   localparam int QW   = rotpt_pkg::Q_BITS;
   localparam int TW   = QW + 1;
   localparam int KW   = TRIG_FRAC_BITS + 1;
   localparam int CW   = TRIG_FRAC_BITS + 2;
   localparam int SH   = QW - TRIG_FRAC_BITS;
   localparam int UW   = rotpt_pkg::UNWRAP_WIDTH;
   localparam int USW  = UW + 1;
   localparam int AW   = rotpt_pkg::ANGLE_WIDTH;
   localparam int RSW  = rotpt_pkg::REST_WIDTH;
   localparam int KNW  = rotpt_pkg::KERN_WIDTH;
   localparam int FW   = rotpt_pkg::XFRAC_WIDTH;
   localparam int XPW  = FW + rotpt_pkg::XRECIP_WIDTH;
   localparam int PRW  = QW + rotpt_pkg::RECIP_WIDTH;
   localparam int MQW  = QW + TW;
   localparam int SQW  = 2 * QW;
   localparam int QUART = rotpt_pkg::QUARTER_UNITS;

   localparam logic [TW-1:0] ONE = {1'b1, {QW{1'b0}}};

   typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_type;

   function automatic logic [QW-1:0] recip_div(
      input logic [QW-1:0]                      num,
      input logic [rotpt_pkg::RECIP_WIDTH-1:0]  recip,
      input int unsigned                        sh
   );
      logic [PRW-1:0] prod;
      prod = PRW'(num) * PRW'(recip);
      return QW'(prod >> sh);
   endfunction

   function automatic logic [QW-1:0] mul_q(
      input logic [QW-1:0] a,
      input logic [TW-1:0] b
   );
      logic [MQW-1:0] prod;
      prod = MQW'(a) * MQW'(b);
      return QW'(prod >> QW);
   endfunction

   // stage registers
   logic [AW-1:0]   ang_ff;
   quad_type        quad_ff [1:11];
   logic            swap_ff [1:11];
   logic [KNW-1:0]  kern_ff;
   logic [FW-1:0]   frac_ff;
   logic [QW-1:0]   base_ff;
   logic [QW-1:0]   x_ff  [3:9];
   logic [QW-1:0]   x2_ff [4:9];
   logic [TW-1:0]   ts1_ff, tc1_ff, ts2_ff, tc2_ff, ts3_ff, tc3_ff;
   logic [QW-1:0]   ps1_ff, pc1_ff, ps2_ff, pc2_ff;
   logic [QW-1:0]   sq_ff, pc3_ff;
   logic [KW-1:0]   sk_ff, ck_ff;
   logic signed [CW-1:0] cos_ff, sin_ff;

   // next values
   logic signed [USW-1:0] unwrap_s;
   logic [UW-1:0]   unwrap;
   logic [AW-1:0]   ang_in;
   quad_type        quad_in;
   logic [RSW-1:0]  rest;
   logic            swap_in;
   logic [KNW-1:0]  kern_in;
   logic [XPW-1:0]  xfrac_prod;
   logic [SQW-1:0]  xsq_prod;
   logic [TW-1:0]   cos_q30;
   logic [KW-1:0]   sk_in, ck_in;
   logic [KW-1:0]   cb_mag, sb_mag;
   logic signed [CW-1:0] cb, sb, cos_in, sin_in;

   // turn modulo one full turn
   always_comb begin
      unwrap_s = USW'(turn) + USW'(rotpt_pkg::TURN_OFFSET);
      unwrap   = unwrap_s[UW-1:0];
      ang_in   = AW'(unwrap);
      for (int n = 1; n <= rotpt_pkg::TURN_WRAPS; n++) begin
         if (unwrap >= UW'(n * rotpt_pkg::TURN_UNITS)) begin
            ang_in = AW'(unwrap - UW'(n * rotpt_pkg::TURN_UNITS));
         end
      end
   end

   // quadrant and octant fold
   always_comb begin
      priority if (ang_ff >= AW'(3 * QUART)) begin
         quad_in = QUAD_3;
         rest    = RSW'(ang_ff - AW'(3 * QUART));
      end else if (ang_ff >= AW'(2 * QUART)) begin
         quad_in = QUAD_2;
         rest    = RSW'(ang_ff - AW'(2 * QUART));
      end else if (ang_ff >= AW'(QUART)) begin
         quad_in = QUAD_1;
         rest    = RSW'(ang_ff - AW'(QUART));
      end else begin
         quad_in = QUAD_0;
         rest    = RSW'(ang_ff);
      end
      swap_in = rest > RSW'(rotpt_pkg::EIGHTH_UNITS);
      kern_in = swap_in ? KNW'(RSW'(QUART) - rest) : KNW'(rest);
   end

   assign xfrac_prod = XPW'(frac_ff) * XPW'(rotpt_pkg::X_DIV_RECIP);
   assign xsq_prod   = SQW'(x_ff[3]) * SQW'(x_ff[3]);
   assign cos_q30    = ONE - TW'(pc3_ff >> 1);

   if (SH == 0) begin : g_noround
      assign sk_in = KW'(sq_ff);
      assign ck_in = KW'(cos_q30);
   end else begin : g_round
      localparam logic [TW-1:0] HALF = TW'(1) << (SH - 1);
      assign sk_in = KW'((TW'(sq_ff) + HALF) >> SH);
      assign ck_in = KW'((cos_q30 + HALF) >> SH);
   end

   always_comb begin
      cb_mag = swap_ff[11] ? sk_ff : ck_ff;
      sb_mag = swap_ff[11] ? ck_ff : sk_ff;
      cb     = $signed({1'b0, cb_mag});
      sb     = $signed({1'b0, sb_mag});
      unique case (quad_ff[11])
         QUAD_0: begin
            cos_in = cb;
            sin_in = sb;
         end
         QUAD_1: begin
            cos_in = -sb;
            sin_in = cb;
         end
         QUAD_2: begin
            cos_in = -cb;
            sin_in = -sb;
         end
         QUAD_3: begin
            cos_in = sb;
            sin_in = -cb;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ang_ff <= ang_in;
      end
      if (stage_en[1]) begin
         quad_ff[1] <= quad_in;
         swap_ff[1] <= swap_in;
         kern_ff    <= kern_in;
      end
      for (int i = 2; i <= 11; i++) begin
         if (stage_en[i]) begin
            quad_ff[i] <= quad_ff[i-1];
            swap_ff[i] <= swap_ff[i-1];
         end
      end
      if (stage_en[2]) begin
         frac_ff <= FW'(FW'(kern_ff) * FW'(rotpt_pkg::X_STEP_FRAC)
                        + FW'(rotpt_pkg::X_ROUND));
         base_ff <= QW'(QW'(kern_ff) * QW'(rotpt_pkg::X_STEP_INT));
      end
      if (stage_en[3]) begin
         x_ff[3] <= base_ff + QW'(xfrac_prod >> rotpt_pkg::X_DIV_SHIFT);
      end
      for (int i = 4; i <= 9; i++) begin
         if (stage_en[i]) begin
            x_ff[i] <= x_ff[i-1];
         end
      end
      if (stage_en[4]) begin
         x2_ff[4] <= QW'(xsq_prod >> QW);
      end
      for (int i = 5; i <= 9; i++) begin
         if (stage_en[i]) begin
            x2_ff[i] <= x2_ff[i-1];
         end
      end
      if (stage_en[5]) begin
         ts1_ff <= ONE - TW'(recip_div(x2_ff[4], rotpt_pkg::DIV_S1_RECIP,
                                       rotpt_pkg::DIV_S1_SHIFT));
         tc1_ff <= ONE - TW'(recip_div(x2_ff[4], rotpt_pkg::DIV_C1_RECIP,
                                       rotpt_pkg::DIV_C1_SHIFT));
      end
      if (stage_en[6]) begin
         ps1_ff <= mul_q(x2_ff[5], ts1_ff);
         pc1_ff <= mul_q(x2_ff[5], tc1_ff);
      end
      if (stage_en[7]) begin
         ts2_ff <= ONE - TW'(recip_div(ps1_ff, rotpt_pkg::DIV_S2_RECIP,
                                       rotpt_pkg::DIV_S2_SHIFT));
         tc2_ff <= ONE - TW'(recip_div(pc1_ff, rotpt_pkg::DIV_C2_RECIP,
                                       rotpt_pkg::DIV_C2_SHIFT));
      end
      if (stage_en[8]) begin
         ps2_ff <= mul_q(x2_ff[7], ts2_ff);
         pc2_ff <= mul_q(x2_ff[7], tc2_ff);
      end
      if (stage_en[9]) begin
         ts3_ff <= ONE - TW'(recip_div(ps2_ff, rotpt_pkg::DIV_S3_RECIP,
                                       rotpt_pkg::DIV_S3_SHIFT));
         tc3_ff <= ONE - TW'(recip_div(pc2_ff, rotpt_pkg::DIV_C3_RECIP,
                                       rotpt_pkg::DIV_C3_SHIFT));
      end
      if (stage_en[10]) begin
         sq_ff  <= mul_q(x_ff[9], ts3_ff);
         pc3_ff <= mul_q(x2_ff[9], tc3_ff);
      end
      if (stage_en[11]) begin
         sk_ff <= sk_in;
         ck_ff <= ck_in;
      end
      if (stage_en[12]) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

FILE: sv/rotpt_rot.sv
// ----------------------------------------------------------------------------
// rotpt_rot
// offset from origin, rotation products, rounding and saturating add-back
// ----------------------------------------------------------------------------
module rotpt_rot #(
   parameter int TRIG_FRAC_BITS = rotpt_pkg::TRIG_FRAC_BITS
) (
   input  logic                               clock,
   input  logic [rotpt_pkg::NUM_STAGES-1:0]   stage_en,
   input  rotpt_pkg::req_word_type            req_word,
   input  logic signed [TRIG_FRAC_BITS+1:0]   cos_val,
   input  logic signed [TRIG_FRAC_BITS+1:0]   sin_val,
   output rotpt_pkg::rsp_word_type            rsp_word
);

   localparam int XW    = rotpt_pkg::COORD_WIDTH;
   localparam int DW    = XW + 1;
   localparam int PW    = XW + TRIG_FRAC_BITS + 3;
   localparam int RW    = XW + 3;
   localparam int EW    = XW + 4;
   localparam int ST    = rotpt_pkg::STG_TRIG;
   localparam int SPROD = rotpt_pkg::STG_PROD;
   localparam int SSUM  = rotpt_pkg::STG_SUM;
   localparam int SRND  = rotpt_pkg::STG_ROUND;
   localparam int SOUT  = rotpt_pkg::STG_OUT;

   localparam logic signed [PW-1:0] HALF = PW'(1) << (TRIG_FRAC_BITS - 1);

   // returns {clamped, value}
   function automatic logic [XW:0] clamp(input logic signed [EW-1:0] v);
      logic [XW-1:0] lim;
      lim = v[EW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
      if (v[EW-1:XW-1] == {(EW-XW+1){v[EW-1]}}) begin
         return {1'b0, v[XW-1:0]};
      end
      return {1'b1, lim};
   endfunction

   logic signed [DW-1:0] dx_ff [0:ST];
   logic signed [DW-1:0] dy_ff [0:ST];
   logic signed [XW-1:0] ox_ff [0:SRND];
   logic signed [XW-1:0] oy_ff [0:SRND];
   logic signed [PW-1:0] mxc_ff, mys_ff, mxs_ff, myc_ff;
   logic signed [PW-1:0] sx_ff, sy_ff;
   logic signed [RW-1:0] rx_ff, ry_ff;
   rotpt_pkg::rsp_word_type rsp_word_ff;

   logic signed [PW-1:0] rx_sum, ry_sum;
   logic signed [RW-1:0] rx_in, ry_in;
   logic signed [EW-1:0] ex, ey;
   logic [XW:0]          cx, cy;
   rotpt_pkg::rsp_word_type rsp_word_in;

   // round half away from zero
   always_comb begin
      rx_sum = sx_ff + HALF - $signed(PW'(sx_ff[PW-1]));
      ry_sum = sy_ff + HALF - $signed(PW'(sy_ff[PW-1]));
      rx_in  = RW'(rx_sum >>> TRIG_FRAC_BITS);
      ry_in  = RW'(ry_sum >>> TRIG_FRAC_BITS);
   end

   always_comb begin
      ex = EW'(ox_ff[SRND]) + EW'(rx_ff);
      ey = EW'(oy_ff[SRND]) + EW'(ry_ff);
      cx = clamp(ex);
      cy = clamp(ey);
      rsp_word_in.rotated_x = cx[XW-1:0];
      rsp_word_in.rotated_y = cy[XW-1:0];
      rsp_word_in.saturated = cx[XW] | cy[XW];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dx_ff[0] <= DW'(req_word.point_x) - DW'(req_word.origin_x);
         dy_ff[0] <= DW'(req_word.point_y) - DW'(req_word.origin_y);
         ox_ff[0] <= req_word.origin_x;
         oy_ff[0] <= req_word.origin_y;
      end
      for (int i = 1; i <= ST; i++) begin
         if (stage_en[i]) begin
            dx_ff[i] <= dx_ff[i-1];
            dy_ff[i] <= dy_ff[i-1];
         end
      end
      for (int i = 1; i <= SRND; i++) begin
         if (stage_en[i]) begin
            ox_ff[i] <= ox_ff[i-1];
            oy_ff[i] <= oy_ff[i-1];
         end
      end
      if (stage_en[SPROD]) begin
         mxc_ff <= PW'(dx_ff[ST]) * PW'(cos_val);
         mys_ff <= PW'(dy_ff[ST]) * PW'(sin_val);
         mxs_ff <= PW'(dx_ff[ST]) * PW'(sin_val);
         myc_ff <= PW'(dy_ff[ST]) * PW'(cos_val);
      end
      if (stage_en[SSUM]) begin
         sx_ff <= mxc_ff - mys_ff;
         sy_ff <= mxs_ff + myc_ff;
      end
      if (stage_en[SRND]) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
      if (stage_en[SOUT]) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

FILE: sv/rotate_point_by_turn_percent_core.sv
// ----------------------------------------------------------------------------
// rotate_point_by_turn_percent_core
// Rotates a point about an origin by a turn given in hundredths of a percent
// (10000 = one full turn, counter-clockwise positive, any 16-bit value taken
// modulo one turn). Sine and cosine come from a fully pipelined q30 Taylor
// polynomial, so a new word is accepted every clock unless req_stall is high.
// The pipeline has 17 register stages; a result word turns valid when it reaches
// the last stage and stays there while the output is stalled.
// Each rotated offset is rounded half away from zero and added back to the
// origin; coordinates beyond the signed range are clamped and flag saturated.
// Empty stages close up while the output is stalled, so words keep entering
// until all 17 stages are full.
// ----------------------------------------------------------------------------
module rotate_point_by_turn_percent_core #(
   parameter int TRIG_FRAC_BITS = rotpt_pkg::TRIG_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rotpt_pkg::req_word_type   req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rotpt_pkg::rsp_word_type   rsp_word
);

   logic [rotpt_pkg::NUM_STAGES-1:0]  stage_en;
   logic signed [TRIG_FRAC_BITS+1:0]  cos_val;
   logic signed [TRIG_FRAC_BITS+1:0]  sin_val;

   rotpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stage_en  (stage_en)
   );

   rotpt_trig #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_trig (
      .clock    (clock),
      .stage_en (stage_en[rotpt_pkg::STG_TRIG:0]),
      .turn     (req_word.turn_hundredths),
      .cos_val  (cos_val),
      .sin_val  (sin_val)
   );

   rotpt_rot #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_rot (
      .clock    (clock),
      .stage_en (stage_en),
      .req_word (req_word),
      .cos_val  (cos_val),
      .sin_val  (sin_val),
      .rsp_word (rsp_word)
   );

endmodule
